// ===== hw/rtl/frcrc_pkg.sv =====
// ---------------------------------------------------------------------------
// frcrc_pkg
// Shared types, character codes and CRC-8 fold for the framed receiver.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package frcrc_pkg;

   localparam int FRAME_BYTES_DEF = 32;

   localparam logic [7:0] CH_SOH          = 8'h01;
   localparam logic [7:0] CH_EOT          = 8'h04;
   localparam logic [7:0] CH_ESC          = 8'h1B;
   localparam logic [7:0] CHECK_INIT      = 8'hFF;
   localparam logic [7:0] CHECK_GOOD      = 8'hCF;
   localparam logic [7:0] CHECK_POLY_REFL = 8'hE0;

   typedef struct packed {
      logic fire;
      logic pass;
   } end_evt_type;

   typedef enum logic [1:0] {
      DR_IDLE,
      DR_READ,
      DR_SHOW
   } drain_state_type;

   // reflected CRC-8, one byte
   function automatic logic [7:0] crc8_fold(input logic [7:0] crc, input logic [7:0] b);
      logic [7:0] c;
      c = crc ^ b;
      for (int k = 0; k < 8; k++) begin
         if (c[0]) begin
            c = (c >> 1) ^ CHECK_POLY_REFL;
         end else begin
            c = c >> 1;
         end
      end
      return c;
   endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/frcrc_ram.sv =====
// ---------------------------------------------------------------------------
// frcrc_ram
// Generic single-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module frcrc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/frcrc_rx.sv =====
// ---------------------------------------------------------------------------
// frcrc_rx
// Byte parser: SOH/ESC/EOT handling, buffer write, running CRC-8, count.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module frcrc_rx #(
   parameter int FRAME_BYTES = frcrc_pkg::FRAME_BYTES_DEF
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           take,
   input  wire logic [7:0]                     rx_byte,
   output logic                                wr_en,
   output logic [$clog2(FRAME_BYTES)-1:0]      wr_addr,
   output logic [7:0]                          wr_data,
   output frcrc_pkg::end_evt_type              end_evt,
   output logic [$clog2(FRAME_BYTES)-1:0]      last_idx
);
   import frcrc_pkg::*;

   localparam int CW = $clog2(FRAME_BYTES);

   logic [CW-1:0] count_ff, count_in;
   logic          open_ff, open_in;
   logic          esc_ff, esc_in;
   logic [7:0]    crc_ff, crc_in;
   logic          is_soh, is_eot, is_esc, store;
   logic [CW:0]   cnt_next;

   always_comb begin
      is_soh   = (rx_byte == CH_SOH) && !esc_ff;
      is_eot   = (rx_byte == CH_EOT) && !esc_ff;
      is_esc   = (rx_byte == CH_ESC) && !esc_ff;
      store    = take && !is_soh && !is_eot && !is_esc && open_ff;
      cnt_next = {1'b0, count_ff} + (CW+1)'(1);

      count_in = count_ff;
      open_in  = open_ff;
      esc_in   = esc_ff;
      crc_in   = crc_ff;
      if (take) begin
         priority if (is_soh) begin
            open_in = 1'b1;
         end else if (is_eot) begin
            count_in = '0;
            open_in  = 1'b0;
            esc_in   = 1'b0;
            crc_in   = CHECK_INIT;
         end else if (is_esc) begin
            esc_in = 1'b1;
         end else if (open_ff) begin
            if (cnt_next == (CW+1)'(FRAME_BYTES)) begin
               count_in = '0;
               open_in  = 1'b0;
               esc_in   = 1'b0;
               crc_in   = CHECK_INIT;
            end else begin
               count_in = cnt_next[CW-1:0];
               esc_in   = 1'b0;
               crc_in   = crc8_fold(crc_ff, rx_byte);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         open_ff  <= 1'b0;
         esc_ff   <= 1'b0;
         crc_ff   <= CHECK_INIT;
      end else begin
         count_ff <= count_in;
         open_ff  <= open_in;
         esc_ff   <= esc_in;
         crc_ff   <= crc_in;
      end
   end

   assign wr_en        = store;
   assign wr_addr      = count_ff;
   assign wr_data      = rx_byte;
   assign end_evt.fire = take && is_eot;
   assign end_evt.pass = (crc_ff == CHECK_GOOD) && (count_ff != '0);
   assign last_idx     = count_ff - CW'(1);

endmodule

`default_nettype wire

// ===== hw/rtl/frcrc_drain.sv =====
// ---------------------------------------------------------------------------
// frcrc_drain
// Result sequencer: reads the frame buffer byte by byte, or gives a reject.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module frcrc_drain #(
   parameter int FRAME_BYTES = frcrc_pkg::FRAME_BYTES_DEF
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire frcrc_pkg::end_evt_type         end_evt,
   input  wire logic [$clog2(FRAME_BYTES)-1:0] last_idx,
   output logic                                busy,
   output logic                                rd_en,
   output logic [$clog2(FRAME_BYTES)-1:0]      rd_addr,
   input  wire logic [7:0]                     rd_data,
   output logic                                rsp_valid,
   input  wire logic                           rsp_stall,
   output logic                                rsp_status,
   output logic [7:0]                          rsp_payload,
   output logic                                rsp_last
);
   import frcrc_pkg::*;

   localparam int CW = $clog2(FRAME_BYTES);

   drain_state_type state_ff, state_in;
   logic [CW-1:0]   idx_ff, idx_in;
   logic [CW-1:0]   last_ff, last_in;
   logic            reject_ff, reject_in;
   logic            at_last;

   assign at_last = (idx_ff == last_ff);

   // next state
   always_comb begin
      state_in  = state_ff;
      idx_in    = idx_ff;
      last_in   = last_ff;
      reject_in = reject_ff;
      unique case (state_ff)
         DR_IDLE: begin
            if (end_evt.fire) begin
               idx_in    = '0;
               last_in   = last_idx;
               reject_in = !end_evt.pass;
               state_in  = end_evt.pass ? DR_READ : DR_SHOW;
            end
         end
         DR_READ: begin
            state_in = DR_SHOW;
         end
         DR_SHOW: begin
            if (!rsp_stall) begin
               if (reject_ff || at_last) begin
                  state_in = DR_IDLE;
               end else begin
                  idx_in   = idx_ff + CW'(1);
                  state_in = DR_READ;
               end
            end
         end
         default: begin
            state_in = DR_IDLE;
         end
      endcase
   end

   // outputs
   always_comb begin
      busy        = (state_ff != DR_IDLE);
      rd_en       = (state_ff == DR_READ);
      rd_addr     = idx_ff;
      rsp_valid   = (state_ff == DR_SHOW);
      rsp_status  = reject_ff;
      rsp_payload = reject_ff ? 8'h00 : rd_data;
      rsp_last    = reject_ff || at_last;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= DR_IDLE;
         reject_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         reject_ff <= reject_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff  <= idx_in;
      last_ff <= last_in;
   end

endmodule

`default_nettype wire

// ===== hw/rtl/framed_receiver_crc8_fcs_check_top.sv =====
// ---------------------------------------------------------------------------
// framed_receiver_crc8_fcs_check_top
// SOH/ESC/EOT framed receiver with CRC-8 FCS check and frame replay.
// ---------------------------------------------------------------------------
// Idle: one byte per cycle accepted; parser, CRC and buffer write act in the same cycle.
// On EOT the input stalls while results drain; reject shows in the cycle after EOT.
// Passing frame: each byte is read from the buffer (DR_READ), then presented
// (DR_SHOW) until not stalled; after EOT the first byte also passes DR_READ first.
// Reset clears parser and drain control at once; buffer contents are not cleared.
`timescale 1ns / 1ps
`default_nettype none

module framed_receiver_crc8_fcs_check_top #(
   parameter int FRAME_BYTES = frcrc_pkg::FRAME_BYTES_DEF
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_stall,
   input  wire logic [7:0] req_rx_byte,
   output logic            rsp_valid,
   input  wire logic       rsp_stall,
   output logic            rsp_status,
   output logic [7:0]      rsp_payload,
   output logic            rsp_last
);
   import frcrc_pkg::*;

   localparam int CW = $clog2(FRAME_BYTES);

   logic          busy;
   logic          take;
   logic          wr_en;
   logic [CW-1:0] wr_addr;
   logic [7:0]    wr_data;
   logic          rd_en;
   logic [CW-1:0] rd_addr;
   logic [7:0]    rd_data;
   logic [CW-1:0] last_idx;
   end_evt_type   end_evt;

   assign req_stall = busy;
   assign take      = req_valid && !busy;

   frcrc_rx #(.FRAME_BYTES(FRAME_BYTES)) u_rx (
      .clock    (clock),
      .reset    (reset),
      .take     (take),
      .rx_byte  (req_rx_byte),
      .wr_en    (wr_en),
      .wr_addr  (wr_addr),
      .wr_data  (wr_data),
      .end_evt  (end_evt),
      .last_idx (last_idx)
   );

   frcrc_ram #(.WIDTH(8), .DEPTH(FRAME_BYTES)) u_buf (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   frcrc_drain #(.FRAME_BYTES(FRAME_BYTES)) u_drain (
      .clock       (clock),
      .reset       (reset),
      .end_evt     (end_evt),
      .last_idx    (last_idx),
      .busy        (busy),
      .rd_en       (rd_en),
      .rd_addr     (rd_addr),
      .rd_data     (rd_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_status  (rsp_status),
      .rsp_payload (rsp_payload),
      .rsp_last    (rsp_last)
   );

endmodule

`default_nettype wire
